// ===== rtl/wsrs_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wsrs_pkg
// Shared types and codes for the wait/service ratio scheduler.
// ============================================================================
package wsrs_pkg;

    // process slot state codes
    localparam logic [2:0] ST_READY      = 3'd0;
    localparam logic [2:0] ST_RUNNING    = 3'd1;
    localparam logic [2:0] ST_ELIMINATED = 3'd2;
    localparam logic [2:0] ST_ZOMBIE     = 3'd3;
    localparam logic [2:0] ST_WAITING    = 3'd4;
    localparam logic [2:0] ST_STOPPED    = 3'd5;

    // input item function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    // configuration register indexes and reset values
    localparam logic REG_QUANTUM  = 1'b0;
    localparam logic REG_WAIT_DIV = 1'b1;
    localparam logic [15:0] QUANTUM_RST  = 16'd2;
    localparam logic [7:0]  WAIT_DIV_RST = 8'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREV_RD,
        S_PREV_WR,
        S_INC_GO,
        S_INC_WAIT,
        S_SCAN_CHK,
        S_SCAN_RD,
        S_SCAN_DIV,
        S_FIN,
        S_DONE
    } t_fsm;

    // divider handshake toward the shared unit
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

// ===== rtl/wait_service_ratio_scheduler_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wait_service_ratio_scheduler_top
// Highest wait/service ratio scheduler over NUM_PROCS process slots.
// ============================================================================
// Sequence: a set-state item passes through the hand-off state to the output register. A
// tick settles the previous process (if any), divides the quantum for the wait increment,
// then scans the slots; each ready slot's ratio goes through the one shared bit-serial
// divider, of width AW = max(TIME_WIDTH, 16) + 1.
// Throughput: one item at a time; the next is taken once the result is queued.
// Reset: synchronous, active low; times read as zero until first written.
module wait_service_ratio_scheduler_top #(
    parameter int NUM_PROCS  = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [3:0]  i_proc_index,
    input  logic [2:0]  i_proc_state,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_selected_index,
    output logic        o_switched,
    output logic        o_none_ready,
    output logic [4:0]  o_ready_count
);

    localparam int TW = TIME_WIDTH;
    localparam int AW = ((TW > 16) ? TW : 16) + 1;
    localparam int PW = $clog2(NUM_PROCS);
    localparam int CW = $clog2(NUM_PROCS + 1);
    localparam logic [AW:0] LIM = (AW + 1)'({TW{1'b1}});
    localparam logic WIDE64 = (TW == 64);

    // saturating add of a time and an increment
    function automatic logic [TW-1:0] f_sat_add(input logic [TW-1:0] a,
                                                input logic [AW-1:0] b);
        logic [AW:0] s;
        s = (AW + 1)'(a) + (AW + 1)'(b);
        f_sat_add = (s > LIM) ? LIM[TW-1:0] : s[TW-1:0];
    endfunction

    wsrs_pkg::t_fsm r_state, n_state;

    logic [15:0]   r_quantum;
    logic [7:0]    r_wait_div;
    logic [2:0]    r_slot_state [NUM_PROCS];
    logic          r_wvld [NUM_PROCS];
    logic          r_svld [NUM_PROCS];
    logic [PW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_pick, n_pick;
    logic [PW-1:0] r_prev, n_prev;
    logic          r_prev_vld, n_prev_vld;
    logic          r_started, n_started;
    logic          r_first, n_first;
    logic          r_found, n_found;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_best, n_best;
    logic [AW-1:0] r_inc, n_inc;
    logic          r_spec, n_spec;
    logic          r_spec_one, n_spec_one;
    logic [3:0]    r_res_sel, n_res_sel;
    logic          r_res_sw, n_res_sw;
    logic          r_res_none, n_res_none;
    logic [4:0]    r_res_cnt, n_res_cnt;
    logic          r_out_valid, n_out_valid;
    logic [3:0]    r_out_sel;
    logic          r_out_sw;
    logic          r_out_none;
    logic [4:0]    r_out_cnt;

    logic          w_in_acc;
    logic          w_cfg_wr;
    logic [6:0]    w_idx_ext;
    logic [6:0]    w_prev_ext;
    logic [6:0]    w_pick_ext;
    logic [6:0]    w_cnt_ext;
    logic [3:0]    w_prev_out;
    logic [2:0]    w_cur_st;
    logic          w_dead;
    logic [TW-1:0] w_wait_rd;
    logic [TW-1:0] w_serv_rd;
    logic [TW-1:0] w_wait_q;
    logic [TW-1:0] w_serv_q;
    logic [TW-1:0] w_wait_new;
    logic          w_is_prev;
    logic          w_we_wait, w_we_serv;
    logic [TW-1:0] w_wd_wait, w_wd_serv;
    logic [PW-1:0] w_waddr;
    logic [AW-1:0] w_div_a, w_div_b;
    logic [AW-1:0] w_quot;
    logic [AW-1:0] w_ratio;
    logic          w_last;
    logic          w_sw;
    logic          w_out_free;
    wsrs_pkg::t_div_ctl w_div;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_idx_ext  = 7'(i_proc_index);
    assign w_prev_ext = 7'(r_prev);
    assign w_pick_ext = 7'(r_pick);
    assign w_cnt_ext  = 7'(r_cnt);
    assign w_prev_out = r_prev_vld ? w_prev_ext[3:0] : 4'd0;
    assign w_cur_st   = r_slot_state[r_cur];
    assign w_dead     = (w_cur_st == wsrs_pkg::ST_ELIMINATED) ||
                        (w_cur_st == wsrs_pkg::ST_ZOMBIE) ||
                        (w_cur_st == wsrs_pkg::ST_WAITING) ||
                        (w_cur_st == wsrs_pkg::ST_STOPPED);
    assign w_wait_rd  = r_wvld[r_cur] ? w_wait_q : '0;
    assign w_serv_rd  = r_svld[r_cur] ? w_serv_q : '0;
    assign w_is_prev  = r_prev_vld && (r_cur == r_prev);
    assign w_wait_new = w_is_prev ? w_wait_rd : f_sat_add(w_wait_rd, r_inc);
    assign w_last     = (r_cur == PW'(NUM_PROCS - 1));
    assign w_sw       = !r_prev_vld || (r_pick != r_prev);
    assign w_ratio    = r_spec ? AW'(r_spec_one) : w_quot;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_waddr    = (r_state == wsrs_pkg::S_FIN) ? r_pick : r_cur;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum  <= wsrs_pkg::QUANTUM_RST;
            r_wait_div <= wsrs_pkg::WAIT_DIV_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == wsrs_pkg::REG_QUANTUM) begin
                r_quantum <= pwdata[15:0];
            end else begin
                r_wait_div <= pwdata[7:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == wsrs_pkg::REG_WAIT_DIV) ? 32'(r_wait_div) : 32'(r_quantum);

    // slot states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PROCS; k++) begin
                r_slot_state[k] <= (k < 3) ? wsrs_pkg::ST_READY : wsrs_pkg::ST_ELIMINATED;
            end
        end else begin
            if (w_in_acc && i_func == wsrs_pkg::FUNC_SET && w_idx_ext < 7'(NUM_PROCS)) begin
                r_slot_state[w_idx_ext[PW-1:0]] <= i_proc_state;
            end
            if (w_in_acc && i_func == wsrs_pkg::FUNC_TICK && !r_started) begin
                r_slot_state[0] <= wsrs_pkg::ST_READY;
                r_slot_state[1] <= wsrs_pkg::ST_READY;
                r_slot_state[2] <= wsrs_pkg::ST_READY;
            end
            if (r_state == wsrs_pkg::S_PREV_WR && !w_dead) begin
                r_slot_state[r_cur] <= wsrs_pkg::ST_READY;
            end
            if (r_state == wsrs_pkg::S_FIN && r_found && w_sw) begin
                r_slot_state[r_pick] <= wsrs_pkg::ST_RUNNING;
            end
        end
    end

    // written flags of the time memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PROCS; k++) begin
                r_wvld[k] <= 1'b0;
                r_svld[k] <= 1'b0;
            end
        end else begin
            if (w_we_wait) begin
                r_wvld[w_waddr] <= 1'b1;
            end
            if (w_we_serv) begin
                r_svld[w_waddr] <= 1'b1;
            end
        end
    end

    wsrs_ram #(.WIDTH(TW), .DEPTH(NUM_PROCS)) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_wait),
        .i_waddr (w_waddr),
        .i_wdata (w_wd_wait),
        .i_raddr (r_cur),
        .o_rdata (w_wait_q)
    );

    wsrs_ram #(.WIDTH(TW), .DEPTH(NUM_PROCS)) u_serv_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_serv),
        .i_waddr (w_waddr),
        .i_wdata (w_wd_serv),
        .i_raddr (r_cur),
        .o_rdata (w_serv_q)
    );

    wsrs_div #(.WIDTH(AW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div.start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_done     (w_div.done),
        .o_quot     (w_quot)
    );

    // state register and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wsrs_pkg::S_IDLE;
            r_prev_vld  <= 1'b0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_prev_vld  <= n_prev_vld;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            r_cnt       <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_pick     <= n_pick;
        r_prev     <= n_prev;
        r_first    <= n_first;
        r_best     <= n_best;
        r_inc      <= n_inc;
        r_spec     <= n_spec;
        r_spec_one <= n_spec_one;
        r_res_sel  <= n_res_sel;
        r_res_sw   <= n_res_sw;
        r_res_none <= n_res_none;
        r_res_cnt  <= n_res_cnt;
        if (r_state == wsrs_pkg::S_DONE && w_out_free) begin
            r_out_sel  <= r_res_sel;
            r_out_sw   <= r_res_sw;
            r_out_none <= r_res_none;
            r_out_cnt  <= r_res_cnt;
        end
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_pick      = r_pick;
        n_prev      = r_prev;
        n_prev_vld  = r_prev_vld;
        n_started   = r_started;
        n_first     = r_first;
        n_found     = r_found;
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_inc       = r_inc;
        n_spec      = r_spec;
        n_spec_one  = r_spec_one;
        n_res_sel   = r_res_sel;
        n_res_sw    = r_res_sw;
        n_res_none  = r_res_none;
        n_res_cnt   = r_res_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        w_we_wait   = 1'b0;
        w_we_serv   = 1'b0;
        w_wd_wait   = '0;
        w_wd_serv   = '0;
        w_div.start = 1'b0;
        w_div_a     = AW'(r_quantum);
        w_div_b     = (r_wait_div == 8'd0) ? AW'(1) : AW'(r_wait_div);

        unique case (r_state)
            wsrs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_func == wsrs_pkg::FUNC_SET) begin
                        n_res_sel  = w_prev_out;
                        n_res_sw   = 1'b0;
                        n_res_none = 1'b0;
                        n_res_cnt  = '0;
                        n_state    = wsrs_pkg::S_DONE;
                    end else begin
                        n_first   = !r_started;
                        n_started = 1'b1;
                        n_found   = 1'b0;
                        n_cnt     = '0;
                        n_best    = '0;
                        n_cur     = r_prev;
                        n_state   = r_prev_vld ? wsrs_pkg::S_PREV_RD : wsrs_pkg::S_INC_GO;
                    end
                end
            end
            wsrs_pkg::S_PREV_RD: begin
                // wait for the time memories
                n_state = wsrs_pkg::S_PREV_WR;
            end
            wsrs_pkg::S_PREV_WR: begin
                // settle the previous process
                w_we_serv = 1'b1;
                w_wd_serv = f_sat_add(w_dead ? TW'(1) : w_serv_rd, AW'(r_quantum));
                w_we_wait = w_dead;
                w_wd_wait = TW'(1);
                n_state   = wsrs_pkg::S_INC_GO;
            end
            wsrs_pkg::S_INC_GO: begin
                w_div.start = 1'b1;
                n_state     = wsrs_pkg::S_INC_WAIT;
            end
            wsrs_pkg::S_INC_WAIT: begin
                if (w_div.done) begin
                    n_inc   = w_quot;
                    n_cur   = r_first ? PW'(0) : PW'(1);
                    n_state = wsrs_pkg::S_SCAN_CHK;
                end
            end
            wsrs_pkg::S_SCAN_CHK: begin
                if (w_cur_st == wsrs_pkg::ST_READY) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = wsrs_pkg::S_SCAN_RD;
                end else if (w_last) begin
                    n_state = wsrs_pkg::S_FIN;
                end else begin
                    n_cur = r_cur + 1'b1;
                end
            end
            wsrs_pkg::S_SCAN_RD: begin
                // age the wait time and start the ratio
                w_we_wait   = !w_is_prev;
                w_wd_wait   = w_wait_new;
                w_div.start = 1'b1;
                w_div_a     = AW'(w_wait_new);
                w_div_b     = AW'(w_serv_rd) + AW'(1);
                n_spec      = WIDE64 && (&w_serv_rd);
                n_spec_one  = &w_wait_new;
                n_state     = wsrs_pkg::S_SCAN_DIV;
            end
            wsrs_pkg::S_SCAN_DIV: begin
                if (w_div.done) begin
                    if (!r_found || w_ratio > r_best) begin
                        n_found = 1'b1;
                        n_best  = w_ratio;
                        n_pick  = r_cur;
                    end
                    if (w_last) begin
                        n_state = wsrs_pkg::S_FIN;
                    end else begin
                        n_cur   = r_cur + 1'b1;
                        n_state = wsrs_pkg::S_SCAN_CHK;
                    end
                end
            end
            wsrs_pkg::S_FIN: begin
                if (r_found) begin
                    w_we_serv  = (r_pick <= PW'(2));
                    w_we_wait  = (r_pick <= PW'(2));
                    w_wd_serv  = TW'({r_cnt, 1'b0});
                    w_wd_wait  = '0;
                    n_res_sel  = w_pick_ext[3:0];
                    n_res_sw   = w_sw;
                    n_res_none = 1'b0;
                    n_res_cnt  = w_cnt_ext[4:0];
                    if (w_sw) begin
                        n_prev     = r_pick;
                        n_prev_vld = 1'b1;
                    end
                end else begin
                    n_res_sel  = w_prev_out;
                    n_res_sw   = 1'b0;
                    n_res_none = 1'b1;
                    n_res_cnt  = '0;
                end
                n_state = wsrs_pkg::S_DONE;
            end
            wsrs_pkg::S_DONE: begin
                // hand the result to the output register
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = wsrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wsrs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_selected_index = r_out_sel;
    assign o_switched       = r_out_sw;
    assign o_none_ready     = r_out_none;
    assign o_ready_count    = r_out_cnt;

    // divider results only arrive while the sequencer waits for them
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == wsrs_pkg::S_INC_WAIT || r_state == wsrs_pkg::S_SCAN_DIV))
        else $error("divider result outside a wait state");

    // a new result comes only from the hand-off state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == wsrs_pkg::S_DONE)
        else $error("result raised outside hand-off");

    // a switch never reports an empty scan
    a_sw_not_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_sw && r_out_none))
        else $error("switch with no ready slot");

    // ready count never exceeds the slot count
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NUM_PROCS))
        else $error("ready count out of range");

endmodule

// ===== rtl/wsrs_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wsrs_ram
// Generic one-write, one-read RAM with registered read data.
// ============================================================================
module wsrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wsrs_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wsrs_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ============================================================================
module wsrs_div #(
    parameter int WIDTH = 33
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot
);

    localparam int CNTW = $clog2(WIDTH + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_dsr;
    logic [WIDTH:0]   w_shift;
    logic [WIDTH:0]   w_trial;

    // shift in the next dividend bit and try a subtract
    assign w_shift = {r_rem, r_quo[WIDTH-1]};
    assign w_trial = w_shift - {1'b0, r_dsr};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[WIDTH]) begin
                r_rem <= w_trial[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[WIDTH-1:0];
                r_quo <= {r_quo[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
